// ===== rtl/kufef_pkg.sv =====
// Package: types and constants shared by the union-find edge filter.
package kufef_pkg;
    localparam int NODE_W = 8;
    localparam int RANK_W = 4;
    localparam int NODES = 256;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic CMD_MAKE = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        node_a;
        logic [7:0]        node_b;
        logic signed [15:0] edge_cost;
    } in_item_t;

    typedef struct packed {
        logic              taken;
        logic [7:0]        out_a;
        logic [7:0]        out_b;
        logic signed [15:0] out_cost;
    } out_item_t;
endpackage

// ===== rtl/kufef_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module kufef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/kruskal_union_find_edge_filter.sv =====
// Top level: disjoint-set edge filter with path compression over parent/rank RAMs.
// Make: writes parent=self, rank=0 on accept, then registers the result. Edge: walks each
// node to its root, then rewrites every node on that path to point at the root, then
// reads both ranks and joins by rank if the roots differ. One item at a time: the next
// is accepted once the result is registered, later while m_ready holds back an earlier result.
// Reset: clearing all 256 entries sets parent=index, rank=0; no item is accepted until it ends.
module kruskal_union_find_edge_filter import kufef_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FRD   = 4'd2;  // read issued for walk node
    localparam logic [3:0] ST_FCHK  = 4'd3;  // parent data valid
    localparam logic [3:0] ST_CRD   = 4'd4;  // compression read
    localparam logic [3:0] ST_CWR   = 4'd5;  // compression write
    localparam logic [3:0] ST_RKRD  = 4'd6;  // read rank of ra
    localparam logic [3:0] ST_RKRB  = 4'd7;  // read rank of rb
    localparam logic [3:0] ST_JOIN  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [NODE_W:0]   clr_reg, clr_next;
    in_item_t          item_reg, item_next;
    logic              side_reg, side_next;   // 0: walking a, 1: walking b
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [RANK_W-1:0] rka_reg, rka_next;
    logic              taken_reg, taken_next;
    logic              mv_reg, mv_next;
    out_item_t         md_reg, md_next;

    logic              p_we, r_we;
    logic [NODE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata, r_waddr, r_raddr;
    logic [RANK_W-1:0] r_wdata, r_rdata;

    kufef_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));
    kufef_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rank (
        .aclk(aclk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata));

    logic [NODE_W-1:0] root_cur;
    assign root_cur = side_reg ? rb_reg : ra_reg;
    // the output register parts the sides: a waiting result only holds ST_OUT
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;
    assign m_data   = md_reg;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        side_next  = side_reg;
        cur_next   = cur_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rka_next   = rka_reg;
        taken_next = taken_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        p_we = 1'b0; p_waddr = cur_reg; p_wdata = root_cur; p_raddr = cur_reg;
        r_we = 1'b0; r_waddr = cur_reg; r_wdata = '0;       r_raddr = ra_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLR: begin
                // sweep every entry to its reset value
                p_we = 1'b1; p_waddr = clr_reg[NODE_W-1:0]; p_wdata = clr_reg[NODE_W-1:0];
                r_we = 1'b1; r_waddr = clr_reg[NODE_W-1:0]; r_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (NODE_W+1)'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next  = s_data;
                    taken_next = 1'b0;
                    if (s_data.cmd == CMD_MAKE) begin
                        p_we = 1'b1; p_waddr = s_data.node_a; p_wdata = s_data.node_a;
                        r_we = 1'b1; r_waddr = s_data.node_a; r_wdata = '0;
                        state_next = ST_OUT;
                    end else begin
                        side_next  = 1'b0;
                        cur_next   = s_data.node_a;
                        ra_next    = s_data.node_a;
                        state_next = ST_FRD;
                    end
                end
            end
            ST_FRD: begin
                // read parent of the walk node held in the root register
                p_raddr    = root_cur;
                state_next = ST_FCHK;
            end
            ST_FCHK: begin
                if (p_rdata == root_cur) begin
                    // root found: restart from the start node for compression
                    cur_next   = side_reg ? item_reg.node_b : item_reg.node_a;
                    state_next = ST_CRD;
                end else begin
                    if (side_reg) rb_next = p_rdata; else ra_next = p_rdata;
                    state_next = ST_FRD;
                end
            end
            ST_CRD: begin
                if (cur_reg == root_cur) begin
                    if (!side_reg) begin
                        side_next  = 1'b1;
                        cur_next   = item_reg.node_b;
                        rb_next    = item_reg.node_b;
                        state_next = ST_FRD;
                    end else begin
                        state_next = ST_RKRD;
                    end
                end else begin
                    p_raddr    = cur_reg;
                    state_next = ST_CWR;
                end
            end
            ST_CWR: begin
                // point this node at the root, advance to its old parent
                p_we       = 1'b1;
                cur_next   = p_rdata;
                state_next = ST_CRD;
            end
            ST_RKRD: begin
                r_raddr = ra_reg;
                state_next = (ra_reg == rb_reg) ? ST_OUT : ST_RKRB;
            end
            ST_RKRB: begin
                rka_next   = r_rdata;
                r_raddr    = rb_reg;
                state_next = ST_JOIN;
            end
            ST_JOIN: begin
                taken_next = 1'b1;
                p_we = 1'b1;
                if (rka_reg < r_rdata) begin
                    p_waddr = ra_reg; p_wdata = rb_reg;
                end else begin
                    p_waddr = rb_reg; p_wdata = ra_reg;
                    if (rka_reg == r_rdata && rka_reg < RANK_MAX) begin
                        r_we = 1'b1; r_waddr = ra_reg; r_wdata = rka_reg + 1'b1;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold here while the previous result still waits
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    md_next.taken    = taken_reg;
                    md_next.out_a    = item_reg.node_a;
                    md_next.out_b    = item_reg.node_b;
                    md_next.out_cost = item_reg.edge_cost;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
        item_reg  <= item_next;
        side_reg  <= side_next;
        cur_reg   <= cur_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rka_reg   <= rka_next;
        taken_reg <= taken_next;
        md_reg    <= md_next;
    end
endmodule
